>>> src/ssn_pkg.sv
`timescale 1ns / 1ps
package ssn_pkg;

    localparam int MAX_LINKS         = 26;
    localparam int NEURON_INDEX_BITS = 10;
    localparam int LINK_IDX_W        = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int LINK_CNT_W        = $clog2(MAX_LINKS + 1);
    localparam int VAL_W             = 24;
    localparam int SIG_W             = 17;
    localparam int USAGE_W           = 18;
    localparam int FRAC_W            = 16;
    localparam int ONE_Q16           = 1 << FRAC_W;
    localparam int USAGE_MAX         = (1 << USAGE_W) - 1;
    localparam int DIV_STEPS         = FRAC_W;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS + 1);
    localparam int MUL_W             = 2 * (VAL_W + 1);
    localparam int WIDE_W            = 36;

    typedef enum logic [2:0] {
        MODE_ACC      = 3'd0,
        MODE_PROC     = 3'd1,
        MODE_XFER     = 3'd2,
        MODE_BACKPROP = 3'd3,
        MODE_DULL     = 3'd4,
        MODE_RESET    = 3'd5,
        MODE_ADD      = 3'd6,
        MODE_SETACT   = 3'd7
    } mode_t;

    typedef struct packed {
        logic latch;
        logic apply;
        logic div_acc;
        logic div_wgt;
        logic set_fire;
        logic usage_upd;
        logic mul_cap;
        logic wgt_wr;
        logic idx_inc;
        logic push_link;
        logic push_status;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  fired;
        logic  links_zero;
        logic  idx_last;
        logic  div_done;
        logic  out_free;
    } dp_stat_t;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'((1 << (VAL_W - 1)) - 1);
        lo = -WIDE_W'(1 << (VAL_W - 1));
        if (v > hi)
            return hi[VAL_W-1:0];
        else if (v < lo)
            return lo[VAL_W-1:0];
        else
            return v[VAL_W-1:0];
    endfunction

endpackage

>>> src/ssn_if.sv
`timescale 1ns / 1ps
interface ssn_in_if
    import ssn_pkg::*;
();
    logic                               valid;
    logic                               ready;
    logic [2:0]                         mode;
    logic signed [VAL_W-1:0]            amount;
    logic [NEURON_INDEX_BITS-1:0]       target_neuron;
    logic                               force_fire;

    modport source (output valid, mode, amount, target_neuron, force_fire, input ready);
    modport sink   (input valid, mode, amount, target_neuron, force_fire, output ready);
endinterface

interface ssn_out_if
    import ssn_pkg::*;
();
    logic                               valid;
    logic                               ready;
    logic                               signal_valid;
    logic [NEURON_INDEX_BITS-1:0]       dest_neuron;
    logic signed [SIG_W-1:0]            signal_value;
    logic                               last;
    logic                               fired;
    logic [LINK_CNT_W-1:0]              link_count;
    logic                               overflow_error;

    modport source (output valid, signal_valid, dest_neuron, signal_value, last, fired,
                    link_count, overflow_error, input ready);
    modport sink   (input valid, signal_valid, dest_neuron, signal_value, last, fired,
                    link_count, overflow_error, output ready);
endinterface

>>> src/ssn_div.sv
`timescale 1ns / 1ps
module ssn_div
    import ssn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [VAL_W-1:0] x,
    output logic                    done,
    output logic signed [SIG_W-1:0] q
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [VAL_W:0]         den_reg;
    logic [VAL_W:0]         rem_reg;
    logic [FRAC_W-1:0]      quo_reg;
    logic                   neg_reg;
    logic [VAL_W-1:0]       mag;
    logic [VAL_W+1:0]       trial;
    logic                   take;

    assign mag   = x[VAL_W-1] ? VAL_W'(-x) : VAL_W'(x);
    assign trial = {rem_reg, 1'b0};
    assign take  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // quotient is below 1.0, so start with the magnitude as partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, mag};
            den_reg <= (VAL_W+1)'(ONE_Q16) + {1'b0, mag};
            neg_reg <= x[VAL_W-1];
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? (VAL_W+1)'(trial - {1'b0, den_reg}) : trial[VAL_W:0];
            quo_reg <= {quo_reg[FRAC_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign q    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

>>> src/ssn_datapath.sv
`timescale 1ns / 1ps
module ssn_datapath
    import ssn_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  dp_cmd_t                         cmd,
    output dp_stat_t                        stat,
    input  logic [2:0]                      in_mode,
    input  logic signed [VAL_W-1:0]         in_amount,
    input  logic [NEURON_INDEX_BITS-1:0]    in_target,
    input  logic                            in_force,
    input  logic                            cfg_wr_en,
    input  logic signed [SIG_W-1:0]         cfg_wr_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            out_signal_valid,
    output logic [NEURON_INDEX_BITS-1:0]    out_dest,
    output logic signed [SIG_W-1:0]         out_value,
    output logic                            out_last,
    output logic                            out_fired,
    output logic [LINK_CNT_W-1:0]           out_count,
    output logic                            out_ovf
);

    mode_t                              mode_reg;
    logic signed [VAL_W-1:0]            amount_reg;
    logic [NEURON_INDEX_BITS-1:0]       target_reg;
    logic                               force_reg;
    logic signed [SIG_W-1:0]            thr_reg;
    logic signed [VAL_W-1:0]            acc_reg;
    logic                               fired_reg;
    logic [LINK_CNT_W-1:0]              links_reg;
    logic                               ovf_reg;
    logic [LINK_IDX_W-1:0]              idx_reg;
    logic signed [VAL_W-1:0]            weight_mem [MAX_LINKS];
    logic [USAGE_W-1:0]                 usage_mem  [MAX_LINKS];
    logic [NEURON_INDEX_BITS-1:0]       dest_mem   [MAX_LINKS];
    logic signed [MUL_W-1:0]            prod_reg;
    logic                               oval_reg;
    logic                               osig_reg;
    logic [NEURON_INDEX_BITS-1:0]       odest_reg;
    logic signed [SIG_W-1:0]            ovalue_reg;
    logic                               olast_reg;
    logic                               ofired_reg;
    logic [LINK_CNT_W-1:0]              ocount_reg;
    logic                               oovf_reg;

    logic                               full;
    logic                               idx_last;
    logic [LINK_IDX_W-1:0]              add_idx;
    logic signed [VAL_W-1:0]            wgt_cur;
    logic [USAGE_W-1:0]                 usage_cur;
    logic [USAGE_W:0]                   usage_sum;
    logic [USAGE_W-1:0]                 usage_next;
    logic                               div_start;
    logic                               div_done;
    logic signed [SIG_W-1:0]            div_q;
    logic signed [VAL_W:0]              mul_a;
    logic signed [VAL_W:0]              mul_b;
    logic signed [MUL_W-FRAC_W-1:0]     prod_scaled;
    logic signed [WIDE_W-1:0]           wgt_sum;
    logic                               out_free;

    assign full      = links_reg >= LINK_CNT_W'(MAX_LINKS);
    assign idx_last  = (LINK_CNT_W'(idx_reg) + LINK_CNT_W'(1)) == links_reg;
    assign add_idx   = links_reg[LINK_IDX_W-1:0];
    assign wgt_cur   = weight_mem[idx_reg];
    assign usage_cur = usage_mem[idx_reg];
    assign out_free  = !oval_reg || out_ready;

    // halve, then add one use when the neuron sends
    always_comb
    begin
        usage_sum = {2'b00, usage_cur[USAGE_W-1:1]};
        if (fired_reg)
            usage_sum = usage_sum + (USAGE_W+1)'(ONE_Q16);
        usage_next = (usage_sum > (USAGE_W+1)'(USAGE_MAX)) ? USAGE_W'(USAGE_MAX)
                                                            : usage_sum[USAGE_W-1:0];
    end

    assign div_start = cmd.div_acc || cmd.div_wgt;

    ssn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (cmd.div_acc ? acc_reg : wgt_cur),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        if (mode_reg == MODE_BACKPROP)
        begin
            mul_a = (VAL_W+1)'(amount_reg);
            mul_b = $signed({{(VAL_W+1-USAGE_W){1'b0}}, usage_cur});
        end
        else
        begin
            mul_a = (VAL_W+1)'(wgt_cur);
            mul_b = (VAL_W+1)'(ONE_Q16) - (VAL_W+1)'(amount_reg);
        end
    end

    // arithmetic shift drops fraction bits toward minus infinity
    assign prod_scaled = prod_reg[MUL_W-1:FRAC_W];
    assign wgt_sum     = (mode_reg == MODE_BACKPROP)
                         ? WIDE_W'(wgt_cur) + WIDE_W'(prod_scaled)
                         : WIDE_W'(prod_scaled);

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg   <= mode_t'(in_mode);
            amount_reg <= in_amount;
            target_reg <= in_target;
            force_reg  <= in_force;
        end
        if (cmd.mul_cap)
            prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply && mode_reg == MODE_ADD && !full)
            weight_mem[add_idx] <= '0;
        if (cmd.wgt_wr)
            weight_mem[idx_reg] <= sat_val(wgt_sum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply && mode_reg == MODE_RESET)
        begin
            for (int i = 0; i < MAX_LINKS; i++)
                usage_mem[i] <= '0;
        end
        else if (cmd.apply && mode_reg == MODE_ADD && !full)
            usage_mem[add_idx] <= '0;
        else if (cmd.usage_upd)
            usage_mem[idx_reg] <= usage_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply && mode_reg == MODE_ADD && !full)
            dest_mem[add_idx] <= target_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= '0;
            acc_reg   <= '0;
            fired_reg <= 1'b0;
            links_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
            if (cmd.latch)
            begin
                ovf_reg <= 1'b0;
                idx_reg <= '0;
            end
            if (cmd.idx_inc)
                idx_reg <= idx_reg + LINK_IDX_W'(1);
            if (cmd.set_fire)
            begin
                fired_reg <= div_q > thr_reg;
                acc_reg   <= '0;
            end
            if (cmd.apply)
            begin
                case (mode_reg)
                    MODE_ACC:    acc_reg <= sat_val(WIDE_W'(acc_reg) + WIDE_W'(amount_reg));
                    MODE_RESET:
                    begin
                        acc_reg   <= '0;
                        fired_reg <= 1'b0;
                    end
                    MODE_ADD:
                    begin
                        if (full)
                            ovf_reg <= 1'b1;
                        else
                            links_reg <= links_reg + LINK_CNT_W'(1);
                    end
                    MODE_SETACT: fired_reg <= force_reg;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            oval_reg <= 1'b0;
        else if (cmd.push_link || cmd.push_status)
            oval_reg <= 1'b1;
        else if (out_ready)
            oval_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_link)
        begin
            osig_reg   <= 1'b1;
            odest_reg  <= dest_mem[idx_reg];
            ovalue_reg <= div_q;
            olast_reg  <= idx_last;
            ofired_reg <= fired_reg;
            ocount_reg <= links_reg;
            oovf_reg   <= 1'b0;
        end
        else if (cmd.push_status)
        begin
            osig_reg   <= 1'b0;
            odest_reg  <= '0;
            ovalue_reg <= '0;
            olast_reg  <= 1'b1;
            ofired_reg <= fired_reg;
            ocount_reg <= links_reg;
            oovf_reg   <= ovf_reg;
        end
    end

    assign stat.mode       = mode_reg;
    assign stat.fired      = fired_reg;
    assign stat.links_zero = links_reg == '0;
    assign stat.idx_last   = idx_last;
    assign stat.div_done   = div_done;
    assign stat.out_free   = out_free;

    assign out_valid        = oval_reg;
    assign out_signal_valid = osig_reg;
    assign out_dest         = odest_reg;
    assign out_value        = ovalue_reg;
    assign out_last         = olast_reg;
    assign out_fired        = ofired_reg;
    assign out_count        = ocount_reg;
    assign out_ovf          = oovf_reg;

endmodule

>>> src/ssn_ctrl.sv
`timescale 1ns / 1ps
module ssn_ctrl
    import ssn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PDIV,
        S_TLINK,
        S_TDIV,
        S_TEMIT,
        S_BMUL,
        S_BWR,
        S_STATUS
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.mode inside {MODE_ACC, MODE_RESET, MODE_ADD, MODE_SETACT})
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_STATUS;
                end
                else if (stat.mode == MODE_PROC)
                begin
                    cmd.div_acc = 1'b1;
                    state_next  = S_PDIV;
                end
                else if (stat.links_zero)
                    state_next = S_STATUS;
                else if (stat.mode == MODE_XFER)
                    state_next = S_TLINK;
                else
                    state_next = S_BMUL;
            end
            S_PDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.set_fire = 1'b1;
                    state_next   = S_STATUS;
                end
            end
            S_TLINK:
            begin
                cmd.usage_upd = 1'b1;
                if (stat.fired)
                begin
                    cmd.div_wgt = 1'b1;
                    state_next  = S_TDIV;
                end
                else if (stat.idx_last)
                    state_next = S_STATUS;
                else
                    cmd.idx_inc = 1'b1;
            end
            S_TDIV:
            begin
                if (stat.div_done)
                    state_next = S_TEMIT;
            end
            S_TEMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.push_link = 1'b1;
                    if (stat.idx_last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_TLINK;
                    end
                end
            end
            S_BMUL:
            begin
                cmd.mul_cap = 1'b1;
                state_next  = S_BWR;
            end
            S_BWR:
            begin
                cmd.wgt_wr = 1'b1;
                if (stat.idx_last)
                    state_next = S_STATUS;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_BMUL;
                end
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.push_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> src/softsign_threshold_neuron_core.sv
`timescale 1ns / 1ps
// One neuron with up to MAX_LINKS outgoing links, weights and accumulator in
// Q8.16, softsign outputs in Q1.16. One request is handled at a time; the
// next is taken as soon as the previous one has placed its last result in the
// output register. Accumulate, reset, add_connection and set_activation are
// applied directly; process runs the 16-step restoring softsign divider;
// backprop and dull visit each of the N links in turn (one shared
// multiplier); transfer updates each link's usage and, when fired, makes
// one divider pass per link. Results stall while the consumer holds ready
// low. The destination table is not cleared at reset.
module softsign_threshold_neuron_core
    import ssn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    ssn_in_if.sink                  in_ch,
    ssn_out_if.source               out_ch,
    input  logic                    cfg_wr_en,
    input  logic signed [SIG_W-1:0] cfg_wr_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ssn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssn_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_mode          (in_ch.mode),
        .in_amount        (in_ch.amount),
        .in_target        (in_ch.target_neuron),
        .in_force         (in_ch.force_fire),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .out_ready        (out_ch.ready),
        .out_valid        (out_ch.valid),
        .out_signal_valid (out_ch.signal_valid),
        .out_dest         (out_ch.dest_neuron),
        .out_value        (out_ch.signal_value),
        .out_last         (out_ch.last),
        .out_fired        (out_ch.fired),
        .out_count        (out_ch.link_count),
        .out_ovf          (out_ch.overflow_error)
    );

endmodule

>>> src/ssn_checker.sv
`timescale 1ns / 1ps
module ssn_checker
    import ssn_pkg::*;
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             signal_valid,
    input logic [NEURON_INDEX_BITS-1:0]     dest_neuron,
    input logic signed [SIG_W-1:0]          signal_value,
    input logic                             last,
    input logic                             fired,
    input logic [LINK_CNT_W-1:0]            link_count,
    input logic                             overflow_error
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !signal_valid |-> last && dest_neuron == '0 && signal_value == '0)
        else $error("status result malformed");

    a_signal_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && signal_valid |-> fired && link_count != '0 && !overflow_error)
        else $error("signal sent without fired neuron or links");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow_error |-> link_count == LINK_CNT_W'(MAX_LINKS))
        else $error("overflow reported with free links");

    a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && signal_valid |-> signal_value != SIG_W'(ONE_Q16))
        else $error("softsign magnitude reached one");

endmodule

bind softsign_threshold_neuron_core ssn_checker u_ssn_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .signal_valid   (out_ch.signal_valid),
    .dest_neuron    (out_ch.dest_neuron),
    .signal_value   (out_ch.signal_value),
    .last           (out_ch.last),
    .fired          (out_ch.fired),
    .link_count     (out_ch.link_count),
    .overflow_error (out_ch.overflow_error)
);

>>> tb/ssn_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces (ssn_in_if, ssn_out_if) come with the RTL
// sources; this file only holds the shared request and response records for the testbench.
package ssn_tb_pkg;
    import ssn_pkg::*;

    typedef struct {
        mode_t                          mode;
        logic signed [VAL_W-1:0]        amount;
        logic [NEURON_INDEX_BITS-1:0]   target_neuron;
        logic                           force_fire;
    } neuron_req_t;

    typedef struct {
        logic                           signal_valid;
        logic [NEURON_INDEX_BITS-1:0]   dest_neuron;
        logic signed [SIG_W-1:0]        signal_value;
        logic                           last;
        logic                           fired;
        logic [LINK_CNT_W-1:0]          link_count;
        logic                           overflow_error;
    } neuron_rsp_t;
endpackage

>>> tb/softsign_threshold_neuron_core_tb.sv
`timescale 1ns / 1ps
module softsign_threshold_neuron_core_tb;
    import ssn_pkg::*;
    import ssn_tb_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic signed [SIG_W-1:0] cfg_wr_data;

    ssn_in_if  in_ch();
    ssn_out_if out_ch();

    softsign_threshold_neuron_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // neuron shadow state
    logic signed [VAL_W-1:0]          nrn_acc;
    logic                             nrn_fired;
    int                               nrn_links;
    logic signed [VAL_W-1:0]          nrn_weight [MAX_LINKS];
    logic [USAGE_W-1:0]               nrn_usage [MAX_LINKS];
    logic [NEURON_INDEX_BITS-1:0]     nrn_dest [MAX_LINKS];
    logic signed [SIG_W-1:0]          nrn_thresh;

    neuron_rsp_t pending_rsp [$];
    int          error_count;
    int          cycle_count;
    int          rsp_count;
    bit          rx_stall_en;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout at cycle %0d", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [SIG_W-1:0] softsign_q16(input logic signed [VAL_W-1:0] x);
        longint mag;
        longint q;
        mag = (x < 0) ? -longint'(x) : longint'(x);
        q = (mag << 16) / (longint'(ONE_Q16) + mag);
        return (x < 0) ? SIG_W'(-q) : SIG_W'(q);
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp24(input longint v);
        if (v > 8388607)
            return 24'sd8388607;
        if (v < -8388608)
            return -24'sd8388608;
        return VAL_W'(v);
    endfunction

    // arithmetic shift gives floor for the scaled-down products
    function automatic longint floor_q16(input longint p);
        return p >>> 16;
    endfunction

    function automatic neuron_rsp_t status_rsp(input logic ovf);
        neuron_rsp_t r;
        r.signal_valid   = 1'b0;
        r.dest_neuron    = '0;
        r.signal_value   = '0;
        r.last           = 1'b1;
        r.fired          = nrn_fired;
        r.link_count     = LINK_CNT_W'(nrn_links);
        r.overflow_error = ovf;
        return r;
    endfunction

    task automatic predict_neuron(input neuron_req_t q);
        neuron_rsp_t r;
        longint      u;
        logic        ovf;
        ovf = 1'b0;
        case (q.mode)
            MODE_ACC:
                nrn_acc = clamp24(longint'(nrn_acc) + longint'(q.amount));
            MODE_PROC:
            begin
                nrn_fired = softsign_q16(nrn_acc) > nrn_thresh;
                nrn_acc = '0;
            end
            MODE_XFER:
            begin
                for (int i = 0; i < nrn_links; i++)
                    nrn_usage[i] = nrn_usage[i] >> 1;
                if (nrn_fired && nrn_links > 0)
                begin
                    for (int i = 0; i < nrn_links; i++)
                    begin
                        u = longint'(nrn_usage[i]) + ONE_Q16;
                        nrn_usage[i] = (u > USAGE_MAX) ? USAGE_W'(USAGE_MAX) : USAGE_W'(u);
                        r = status_rsp(1'b0);
                        r.signal_valid = 1'b1;
                        r.dest_neuron  = nrn_dest[i];
                        r.signal_value = softsign_q16(nrn_weight[i]);
                        r.last         = (i + 1 == nrn_links);
                        pending_rsp.push_back(r);
                    end
                    return;
                end
            end
            MODE_BACKPROP:
                for (int i = 0; i < nrn_links; i++)
                    nrn_weight[i] = clamp24(longint'(nrn_weight[i]) +
                        floor_q16(longint'(q.amount) * longint'(nrn_usage[i])));
            MODE_DULL:
                for (int i = 0; i < nrn_links; i++)
                    nrn_weight[i] = clamp24(floor_q16(longint'(nrn_weight[i]) *
                        (longint'(ONE_Q16) - longint'(q.amount))));
            MODE_RESET:
            begin
                nrn_acc = '0;
                nrn_fired = 1'b0;
                for (int i = 0; i < nrn_links; i++)
                    nrn_usage[i] = '0;
            end
            MODE_ADD:
                if (nrn_links < MAX_LINKS)
                begin
                    nrn_dest[nrn_links]   = q.target_neuron;
                    nrn_weight[nrn_links] = '0;
                    nrn_usage[nrn_links]  = '0;
                    nrn_links++;
                end
                else
                    ovf = 1'b1;
            default:
                nrn_fired = q.force_fire;
        endcase
        pending_rsp.push_back(status_rsp(ovf));
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("Mismatch on result %0d: %s got %0d expected %0d", rsp_count, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        neuron_rsp_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("Unexpected result at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                w = pending_rsp.pop_front();
                if (out_ch.signal_valid !== w.signal_valid)
                    report_mismatch("signal_valid", out_ch.signal_valid, w.signal_valid);
                if (out_ch.dest_neuron !== w.dest_neuron)
                    report_mismatch("dest_neuron", out_ch.dest_neuron, w.dest_neuron);
                if (out_ch.signal_value !== w.signal_value)
                    report_mismatch("signal_value", out_ch.signal_value, w.signal_value);
                if (out_ch.last !== w.last)
                    report_mismatch("last", out_ch.last, w.last);
                if (out_ch.fired !== w.fired)
                    report_mismatch("fired", out_ch.fired, w.fired);
                if (out_ch.link_count !== w.link_count)
                    report_mismatch("link_count", out_ch.link_count, w.link_count);
                if (out_ch.overflow_error !== w.overflow_error)
                    report_mismatch("overflow_error", out_ch.overflow_error, w.overflow_error);
            end
            rsp_count <= rsp_count + 1;
        end
    end

    // receiver stall pattern: runs of ready with occasional stalls
    always @(posedge clk)
    begin
        if (!rx_stall_en)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 9) < 7);
    end

    int burst_left;

    // send one request, with bursty gaps
    task automatic send_req(input neuron_req_t q);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
        burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= q.mode;
        in_ch.amount        <= q.amount;
        in_ch.target_neuron <= q.target_neuron;
        in_ch.force_fire    <= q.force_fire;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_neuron(q);
        in_ch.valid <= 1'b0;
        // hold valid low before the next request drives it
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_threshold(input logic signed [SIG_W-1:0] v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        nrn_thresh = v;
    endtask

    function automatic neuron_req_t mk_req(input mode_t m, input logic signed [VAL_W-1:0] a,
                                           input logic [9:0] t, input logic f);
        neuron_req_t q;
        q.mode = m;
        q.amount = a;
        q.target_neuron = t;
        q.force_fire = f;
        return q;
    endfunction

    function automatic neuron_req_t rand_req();
        neuron_req_t q;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            q.mode = MODE_ACC;
        else if (pick < 42)
            q.mode = MODE_PROC;
        else if (pick < 60)
            q.mode = MODE_XFER;
        else if (pick < 70)
            q.mode = MODE_BACKPROP;
        else if (pick < 76)
            q.mode = MODE_DULL;
        else if (pick < 79)
            q.mode = MODE_RESET;
        else if (pick < 89)
            q.mode = MODE_ADD;
        else
            q.mode = MODE_SETACT;
        // mostly modest values, sometimes full range
        if ($urandom_range(0, 3) == 0)
            q.amount = VAL_W'($urandom);
        else
            q.amount = VAL_W'($signed($urandom_range(0, 262143)) - 131072);
        q.target_neuron = NEURON_INDEX_BITS'($urandom);
        q.force_fire = $urandom_range(0, 3) != 0;
        return q;
    endfunction

    // directed table: request plus a hand-read status where obvious
    typedef struct {
        neuron_req_t req;
        bit          hand;
        logic        fired;
        int          links;
        logic        ovf;
    } dir_row_t;

    dir_row_t dir_rows [$];

    task automatic add_row(input neuron_req_t q, input bit h, input logic f, input int n,
                           input logic o);
        dir_row_t d;
        d.req = q;
        d.hand = h;
        d.fired = f;
        d.links = n;
        d.ovf = o;
        dir_rows.push_back(d);
    endtask

    initial
    begin
        neuron_rsp_t hw;
        error_count = 0;
        cycle_count = 0;
        rsp_count = 0;
        burst_left = 0;
        rx_stall_en = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_ACC;
        in_ch.amount = '0;
        in_ch.target_neuron = '0;
        in_ch.force_fire = 1'b0;
        out_ch.ready = 1'b1;
        nrn_acc = '0;
        nrn_fired = 1'b0;
        nrn_links = 0;
        nrn_thresh = '0;
        for (int i = 0; i < MAX_LINKS; i++)
        begin
            nrn_weight[i] = '0;
            nrn_usage[i] = '0;
            nrn_dest[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(mk_req(MODE_XFER, 24'sd0, 10'd0, 1'b0), 1, 1'b0, 0, 1'b0);
        add_row(mk_req(MODE_ACC, 24'sh7FFFFF, 10'd0, 1'b0), 1, 1'b0, 0, 1'b0);
        add_row(mk_req(MODE_ACC, 24'sh7FFFFF, 10'd0, 1'b0), 1, 1'b0, 0, 1'b0);
        add_row(mk_req(MODE_PROC, 24'sd0, 10'd0, 1'b0), 1, 1'b1, 0, 1'b0);
        add_row(mk_req(MODE_ADD, 24'sd0, 10'h3FF, 1'b0), 1, 1'b1, 1, 1'b0);
        add_row(mk_req(MODE_ADD, 24'sd0, 10'h000, 1'b0), 1, 1'b1, 2, 1'b0);
        add_row(mk_req(MODE_ADD, 24'sd0, 10'h2AA, 1'b0), 1, 1'b1, 3, 1'b0);
        add_row(mk_req(MODE_XFER, 24'sd0, 10'd0, 1'b0), 0, 0, 0, 0);
        add_row(mk_req(MODE_BACKPROP, 24'sh7FFFFF, 10'd0, 1'b0), 0, 0, 0, 0);
        add_row(mk_req(MODE_XFER, 24'sd0, 10'd0, 1'b0), 0, 0, 0, 0);
        add_row(mk_req(MODE_BACKPROP, 24'sh800000, 10'd0, 1'b0), 0, 0, 0, 0);
        add_row(mk_req(MODE_BACKPROP, 24'sh800000, 10'd0, 1'b0), 0, 0, 0, 0);
        add_row(mk_req(MODE_XFER, 24'sd0, 10'd0, 1'b0), 0, 0, 0, 0);
        add_row(mk_req(MODE_DULL, 24'sh800000, 10'd0, 1'b0), 0, 0, 0, 0);
        add_row(mk_req(MODE_DULL, 24'sh7FFFFF, 10'd0, 1'b0), 0, 0, 0, 0);
        add_row(mk_req(MODE_ACC, 24'sh800000, 10'd0, 1'b0), 1, 1'b1, 3, 1'b0);
        add_row(mk_req(MODE_ACC, 24'sh800000, 10'd0, 1'b0), 1, 1'b1, 3, 1'b0);
        add_row(mk_req(MODE_PROC, 24'sd0, 10'd0, 1'b0), 1, 1'b0, 3, 1'b0);
        add_row(mk_req(MODE_SETACT, 24'sd0, 10'd0, 1'b1), 1, 1'b1, 3, 1'b0);
        add_row(mk_req(MODE_RESET, 24'sd0, 10'd0, 1'b0), 1, 1'b0, 3, 1'b0);
        add_row(mk_req(MODE_SETACT, 24'sd0, 10'd0, 1'b0), 1, 1'b0, 3, 1'b0);

        // directed rows: hand-typed status overrides the status just predicted,
        // which is still the newest entry since its result has not yet reached the output
        foreach (dir_rows[k])
        begin
            send_req(dir_rows[k].req);
            if (dir_rows[k].hand)
            begin
                hw.signal_valid   = 1'b0;
                hw.dest_neuron    = '0;
                hw.signal_value   = '0;
                hw.last           = 1'b1;
                hw.fired          = dir_rows[k].fired;
                hw.link_count     = LINK_CNT_W'(dir_rows[k].links);
                hw.overflow_error = dir_rows[k].ovf;
                pending_rsp[pending_rsp.size() - 1] = hw;
            end
        end

        // fill the table and overflow it
        write_threshold(-17'sd65536);
        rx_stall_en = 1;
        while (nrn_links < MAX_LINKS)
            send_req(mk_req(MODE_ADD, 24'sd0, NEURON_INDEX_BITS'($urandom), 1'b0));
        send_req(mk_req(MODE_ADD, 24'sd0, 10'd5, 1'b0));
        send_req(mk_req(MODE_SETACT, 24'sd0, 10'd0, 1'b1));
        send_req(mk_req(MODE_XFER, 24'sd0, 10'd0, 1'b0));
        send_req(mk_req(MODE_BACKPROP, 24'sd40000, 10'd0, 1'b0));
        send_req(mk_req(MODE_XFER, 24'sd0, 10'd0, 1'b0));

        // random phases under several thresholds; reset links each phase via fresh
        // behavior is impossible, so later phases run on the full table
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_threshold(17'sd65535);
                1: write_threshold(17'sd0);
                2: write_threshold(17'sd30000);
                default: write_threshold(-17'sd20000);
            endcase
            rx_stall_en = (ph != 1);
            for (int n = 0; n < 85; n++)
                send_req(rand_req());
        end

        drain_results();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> softsign_threshold_neuron_core.f
src/ssn_pkg.sv
src/ssn_if.sv
src/ssn_div.sv
src/ssn_datapath.sv
src/ssn_ctrl.sv
src/softsign_threshold_neuron_core.sv
src/ssn_checker.sv
tb/ssn_tb_if.sv
tb/softsign_threshold_neuron_core_tb.sv
